FILE: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// SPS parser package
// Shared types and constants for the picture-size parser.
// ----------------------------------------------------------------------------
`default_nettype none
package sps_pkg;

  localparam int unsigned StatusW = 3;
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_NOT_SPS  = 3'd1;
  localparam logic [StatusW-1:0] ST_TRUNC    = 3'd2;
  localparam logic [StatusW-1:0] ST_SCALING  = 3'd3;
  localparam logic [StatusW-1:0] ST_OVERFLOW = 3'd4;

  // Queue entry between the byte front end and the bit walker.
  typedef struct packed {
    logic [7:0] data;
    logic       drop;   // emulation-prevention byte: no bits, only the last flag
    logic       last;
  } byte_entry_t;

  // Summary handed from the walker to the result stage on the last byte.
  typedef struct packed {
    logic [15:0]        width_mbs;
    logic [15:0]        height_units;
    logic [1:0]         chroma;
    logic               frame_only;
    logic [15:0]        crop_l;
    logic [15:0]        crop_r;
    logic [15:0]        crop_t;
    logic [15:0]        crop_b;
    logic [31:0]        tick;
    logic [31:0]        tscale;
    logic [StatusW-1:0] status;
  } walk_result_t;

endpackage
`default_nettype wire

FILE: rtl/sps_front.sv
// ----------------------------------------------------------------------------
// SPS byte front end
// Tracks zero runs, flags emulation-prevention bytes and queues bytes.
// ----------------------------------------------------------------------------
`default_nettype none
module sps_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire [7:0]           in_byte_i,
  input  wire                 in_last_i,
  output logic                q_valid_o,
  input  wire                 q_pop_i,
  output sps_pkg::byte_entry_t q_entry_o
);
  localparam int unsigned Depth = 4;

  sps_pkg::byte_entry_t mem_q [Depth];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] zrun_q, zrun_d;
  logic push;
  sps_pkg::byte_entry_t ent;

  assign in_ready_o = (cnt_q != 3'(Depth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 3'd0);
  assign q_entry_o = mem_q[rd_q];

  always_comb begin
    ent.data = in_byte_i;
    ent.last = in_last_i;
    ent.drop = (zrun_q == 2'd2) && (in_byte_i == 8'h03);
    zrun_d = zrun_q;
    if (push) begin
      if (ent.drop) begin
        zrun_d = 2'd0;
      end else if (in_byte_i == 8'h00) begin
        zrun_d = (zrun_q == 2'd2) ? 2'd2 : zrun_q + 2'd1;
      end else begin
        zrun_d = 2'd0;
      end
      if (in_last_i) begin
        zrun_d = 2'd0;
      end
    end
    wr_d = push ? wr_q + 2'd1 : wr_q;
    rd_d = q_pop_i ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'd0, push} - {2'd0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
      zrun_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
      zrun_q <= zrun_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ent;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sps_walker.sv
// ----------------------------------------------------------------------------
// SPS syntax walker
// Consumes queued bytes one bit per cycle, while a byte is queued and no result is waiting, and walks the SPS syntax.
// ----------------------------------------------------------------------------
`default_nettype none
module sps_walker #(
  parameter int unsigned MAX_GOLOMB_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  output logic                  q_pop_o,
  input  sps_pkg::byte_entry_t  q_entry_i,
  output logic                  res_valid_o,
  input  wire                   res_ready_i,
  output sps_pkg::walk_result_t res_o
);
  typedef enum logic [5:0] {
    S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_RESID,
    S_DEPTHL, S_DEPTHC, S_BYPASS, S_SCALING, S_SCALFLAGS, S_LOG2FN,
    S_POCTYPE, S_POCLSB, S_DELTAZ, S_OFFNR, S_OFFTB, S_CYCLE, S_OFFREF,
    S_NUMREF, S_GAPS, S_WIDTH, S_HEIGHT, S_FRAMEONLY, S_MBAFF, S_DIRECT8,
    S_CROPFLAG, S_CROPL, S_CROPR, S_CROPT, S_CROPB, S_VUI, S_ARFLAG,
    S_ARIDC, S_SARW, S_SARH, S_OVERSCAN, S_OVERAPP, S_VSIG, S_VFMT,
    S_CDESC, S_COLOURS, S_CHROMALOC, S_LOCTOP, S_LOCBOT, S_TIMING,
    S_TICK, S_TSCALE, S_DONE, S_HALT
  } step_e;

  function automatic logic [5:0] flen(step_e s);
    case (s)
      S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_SCALFLAGS, S_ARIDC: flen = 6'd8;
      S_RESID, S_BYPASS, S_SCALING, S_DELTAZ, S_GAPS, S_FRAMEONLY, S_MBAFF,
      S_DIRECT8, S_CROPFLAG, S_VUI, S_ARFLAG, S_OVERSCAN, S_OVERAPP,
      S_VSIG, S_CDESC, S_CHROMALOC, S_TIMING: flen = 6'd1;
      S_SARW, S_SARH: flen = 6'd16;
      S_VFMT: flen = 6'd4;
      S_COLOURS: flen = 6'd24;
      S_TICK, S_TSCALE: flen = 6'd32;
      default: flen = 6'd0;
    endcase
  endfunction

  function automatic logic [15:0] sat16(logic [32:0] v);
    sat16 = (v > 33'd65535) ? 16'hffff : v[15:0];
  endfunction

  localparam int unsigned ZcW = $clog2(MAX_GOLOMB_BITS + 1);

  step_e step_q, step_d;
  logic [ZcW-1:0] zc_q, zc_d;
  logic [5:0] left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic suffix_q, suffix_d;
  logic hp_q, hp_d;
  logic [7:0] rep_q, rep_d;
  logic [15:0] wmb_q, wmb_d, hun_q, hun_d;
  logic [1:0] chroma_q, chroma_d;
  logic fo_q, fo_d;
  logic [15:0] crop_q [4];
  logic [15:0] crop_d [4];
  logic [31:0] tick_q, tick_d, ts_q, ts_d;
  logic [2:0] err_q, err_d;
  logic [2:0] bit_q, bit_d;
  logic out_v_q, out_v_d;
  sps_pkg::walk_result_t out_q, out_d;

  // Work on one bit of the current byte.
  logic bitv, active, endbyte;
  logic cv_fire;
  logic [31:0] cv;
  logic [31:0] nacc;
  logic [32:0] gval;
  logic [2:0] st;

  assign bitv = q_entry_i.data[bit_q];
  assign active = q_valid_i && !out_v_q;
  assign endbyte = q_entry_i.drop || (bit_q == 3'd0);
  assign q_pop_o = active && endbyte;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;

  always_comb begin
    step_d = step_q; zc_d = zc_q; left_d = left_q; acc_d = acc_q;
    suffix_d = suffix_q; hp_d = hp_q; rep_d = rep_q; wmb_d = wmb_q;
    hun_d = hun_q; chroma_d = chroma_q; fo_d = fo_q; crop_d = crop_q;
    tick_d = tick_q; ts_d = ts_q; err_d = err_q; bit_d = bit_q;
    out_v_d = out_v_q; out_d = out_q;
    cv_fire = 1'b0; cv = '0;
    nacc = {acc_q[30:0], bitv};
    gval = ({1'b0, 32'hffff_ffff} >> (6'd32 - 6'(zc_q))) + {1'b0, nacc};
    st = sps_pkg::ST_OK;

    if (out_v_q && res_ready_i) begin
      out_v_d = 1'b0;
    end

    if (active && !q_entry_i.drop && step_q < S_DONE) begin
      if (flen(step_q) == 6'd0) begin
        if (!suffix_q) begin
          if (!bitv) begin
            zc_d = zc_q + 1'b1;
            if (32'(zc_q) + 32'd1 >= 32'(MAX_GOLOMB_BITS)) begin
              err_d = sps_pkg::ST_OVERFLOW;
              step_d = S_HALT;
            end
          end else if (zc_q == '0) begin
            cv_fire = 1'b1;
          end else begin
            suffix_d = 1'b1;
            left_d = 6'(zc_q);
            acc_d = '0;
          end
        end else begin
          acc_d = nacc;
          left_d = left_q - 6'd1;
          if (left_q == 6'd1) begin
            cv_fire = 1'b1;
            cv = gval[31:0];
          end
        end
      end else begin
        acc_d = nacc;
        left_d = left_q - 6'd1;
        if (left_q == 6'd1) begin
          cv_fire = 1'b1;
          cv = nacc;
        end
      end
    end

    if (cv_fire) begin
      step_d = S_HALT;
      case (step_q)
        S_HDR: begin
          if (cv[4:0] != 5'd7) err_d = sps_pkg::ST_NOT_SPS;
          else step_d = S_PROFILE;
        end
        S_PROFILE: begin
          hp_d = (cv == 32'd100) || (cv == 32'd110) || (cv == 32'd122) || (cv == 32'd144);
          step_d = S_CONSTR;
        end
        S_CONSTR: step_d = S_LEVEL;
        S_LEVEL: step_d = S_SPSID;
        S_SPSID: step_d = hp_q ? S_CHROMA : S_LOG2FN;
        S_CHROMA: begin
          chroma_d = (cv > 32'd3) ? 2'd3 : cv[1:0];
          step_d = (cv == 32'd3) ? S_RESID : S_DEPTHL;
        end
        S_RESID: step_d = S_DEPTHL;
        S_DEPTHL: step_d = S_DEPTHC;
        S_DEPTHC: step_d = S_BYPASS;
        S_BYPASS: step_d = S_SCALING;
        S_SCALING: begin
          if (cv != 0) begin
            err_d = sps_pkg::ST_SCALING;
            step_d = S_SCALFLAGS;
          end else step_d = S_LOG2FN;
        end
        S_SCALFLAGS: step_d = S_LOG2FN;
        S_LOG2FN: step_d = S_POCTYPE;
        S_POCTYPE: step_d = (cv == 0) ? S_POCLSB : ((cv == 32'd1) ? S_DELTAZ : S_NUMREF);
        S_POCLSB: step_d = S_NUMREF;
        S_DELTAZ: step_d = S_OFFNR;
        S_OFFNR: step_d = S_OFFTB;
        S_OFFTB: step_d = S_CYCLE;
        S_CYCLE: begin
          if (cv > 32'd255) err_d = sps_pkg::ST_OVERFLOW;
          else begin
            rep_d = cv[7:0];
            step_d = (cv[7:0] != 0) ? S_OFFREF : S_NUMREF;
          end
        end
        S_OFFREF: begin
          rep_d = rep_q - 8'd1;
          step_d = (rep_q != 8'd1) ? S_OFFREF : S_NUMREF;
        end
        S_NUMREF: step_d = S_GAPS;
        S_GAPS: step_d = S_WIDTH;
        S_WIDTH: begin
          wmb_d = sat16({1'b0, cv} + 33'd1);
          step_d = S_HEIGHT;
        end
        S_HEIGHT: begin
          hun_d = sat16({1'b0, cv} + 33'd1);
          step_d = S_FRAMEONLY;
        end
        S_FRAMEONLY: begin
          fo_d = cv[0];
          step_d = cv[0] ? S_DIRECT8 : S_MBAFF;
        end
        S_MBAFF: step_d = S_DIRECT8;
        S_DIRECT8: step_d = S_CROPFLAG;
        S_CROPFLAG: step_d = (cv != 0) ? S_CROPL : S_VUI;
        S_CROPL: begin crop_d[0] = sat16({1'b0, cv}); step_d = S_CROPR; end
        S_CROPR: begin crop_d[1] = sat16({1'b0, cv}); step_d = S_CROPT; end
        S_CROPT: begin crop_d[2] = sat16({1'b0, cv}); step_d = S_CROPB; end
        S_CROPB: begin crop_d[3] = sat16({1'b0, cv}); step_d = S_VUI; end
        S_VUI: step_d = (cv != 0) ? S_ARFLAG : S_DONE;
        S_ARFLAG: step_d = (cv != 0) ? S_ARIDC : S_OVERSCAN;
        S_ARIDC: step_d = (cv == 32'd255) ? S_SARW : S_OVERSCAN;
        S_SARW: step_d = S_SARH;
        S_SARH: step_d = S_OVERSCAN;
        S_OVERSCAN: step_d = (cv != 0) ? S_OVERAPP : S_VSIG;
        S_OVERAPP: step_d = S_VSIG;
        S_VSIG: step_d = (cv != 0) ? S_VFMT : S_CHROMALOC;
        S_VFMT: step_d = S_CDESC;
        S_CDESC: step_d = (cv != 0) ? S_COLOURS : S_CHROMALOC;
        S_COLOURS: step_d = S_CHROMALOC;
        S_CHROMALOC: step_d = (cv != 0) ? S_LOCTOP : S_TIMING;
        S_LOCTOP: step_d = S_LOCBOT;
        S_LOCBOT: step_d = S_TIMING;
        S_TIMING: step_d = (cv != 0) ? S_TICK : S_DONE;
        S_TICK: begin tick_d = cv; step_d = S_TSCALE; end
        S_TSCALE: begin ts_d = cv; step_d = S_DONE; end
        default: step_d = S_HALT;
      endcase
      zc_d = '0;
      acc_d = '0;
      suffix_d = 1'b0;
      left_d = flen(step_d);
    end

    if (active) begin
      bit_d = endbyte ? 3'd7 : bit_q - 3'd1;
      if (endbyte && q_entry_i.last) begin
        if (err_d == sps_pkg::ST_NOT_SPS || err_d == sps_pkg::ST_OVERFLOW) st = err_d;
        else if (step_d != S_DONE) st = sps_pkg::ST_TRUNC;
        else st = err_d;
        out_d.width_mbs = wmb_d;
        out_d.height_units = hun_d;
        out_d.chroma = chroma_d;
        out_d.frame_only = fo_d;
        out_d.crop_l = crop_d[0];
        out_d.crop_r = crop_d[1];
        out_d.crop_t = crop_d[2];
        out_d.crop_b = crop_d[3];
        out_d.tick = tick_d;
        out_d.tscale = ts_d;
        out_d.status = st;
        out_v_d = 1'b1;
        // Back to the reset state for the next unit.
        step_d = S_HDR; zc_d = '0; left_d = 6'd8; acc_d = '0; suffix_d = 1'b0;
        hp_d = 1'b0; rep_d = '0; wmb_d = '0; hun_d = '0; chroma_d = 2'd1;
        fo_d = 1'b1; crop_d = '{default: 16'd0}; tick_d = '0; ts_d = '0;
        err_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_HDR; zc_q <= '0; left_q <= 6'd8; acc_q <= '0; suffix_q <= 1'b0;
      hp_q <= 1'b0; rep_q <= '0; wmb_q <= '0; hun_q <= '0; chroma_q <= 2'd1;
      fo_q <= 1'b1; crop_q <= '{default: 16'd0}; tick_q <= '0; ts_q <= '0;
      err_q <= '0; bit_q <= 3'd7; out_v_q <= 1'b0;
    end else begin
      step_q <= step_d; zc_q <= zc_d; left_q <= left_d; acc_q <= acc_d;
      suffix_q <= suffix_d; hp_q <= hp_d; rep_q <= rep_d; wmb_q <= wmb_d;
      hun_q <= hun_d; chroma_q <= chroma_d; fo_q <= fo_d; crop_q <= crop_d;
      tick_q <= tick_d; ts_q <= ts_d; err_q <= err_d; bit_q <= bit_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end
endmodule
`default_nettype wire

FILE: rtl/sps_result.sv
// ----------------------------------------------------------------------------
// SPS result stage
// Computes cropped sizes and the frame rate with a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module sps_result (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   res_valid_i,
  output logic                  res_ready_o,
  input  sps_pkg::walk_result_t res_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [15:0]           width_o,
  output logic [15:0]           height_o,
  output logic [30:0]           rate_o,
  output logic [2:0]            status_o
);
  typedef enum logic [1:0] {R_IDLE, R_SIZE, R_DIV, R_OUT} rstate_e;

  rstate_e st_q;
  logic [5:0] cnt_q;
  logic [32:0] den_q;          // 2 * tick
  logic [31:0] quo_q;          // dividend shifts out, quotient shifts in
  logic [33:0] rem_q;
  sps_pkg::walk_result_t in_q;
  logic [15:0] w_q, h_q;
  logic [2:0] stat_q;
  logic good;

  logic [1:0] ux;
  logic [2:0] uy;
  logic [1:0] fm;
  logic signed [22:0] wv, hv;
  logic [33:0] rsh;
  logic [33:0] rsub;

  assign good = (in_q.status == sps_pkg::ST_OK) || (in_q.status == sps_pkg::ST_SCALING);
  assign res_ready_o = (st_q == R_IDLE);
  assign out_valid_o = (st_q == R_OUT);
  assign width_o = w_q;
  assign height_o = h_q;
  assign status_o = stat_q;
  assign rate_o = quo_q[30:0];

  always_comb begin
    fm = in_q.frame_only ? 2'd1 : 2'd2;
    case (in_q.chroma)
      2'd0: begin ux = 2'd1; uy = {1'b0, fm}; end
      2'd1: begin ux = 2'd2; uy = {fm, 1'b0}; end
      2'd2: begin ux = 2'd2; uy = {1'b0, fm}; end
      default: begin ux = 2'd1; uy = {1'b0, fm}; end
    endcase
    wv = $signed({3'b0, in_q.width_mbs, 4'b0})
         - $signed({3'b0, 20'(ux * ({2'b0, in_q.crop_l} + {2'b0, in_q.crop_r}))});
    hv = $signed({2'b0, fm == 2'd2 ? {in_q.height_units, 5'b0} : {1'b0, in_q.height_units, 4'b0}})
         - $signed({3'b0, 20'(uy * ({3'b0, in_q.crop_t} + {3'b0, in_q.crop_b}))});
    rsh = {rem_q[32:0], quo_q[31]};
    rsub = rsh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= R_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        R_IDLE: if (res_valid_i) st_q <= R_SIZE;
        R_SIZE: begin
          cnt_q <= 6'd32;
          st_q <= (good && in_q.tick != 0) ? R_DIV : R_OUT;
        end
        R_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) st_q <= R_OUT;
        end
        R_OUT: if (out_ready_i) st_q <= R_IDLE;
        default: st_q <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      R_IDLE: in_q <= res_i;
      R_SIZE: begin
        stat_q <= in_q.status;
        w_q <= !good ? 16'd0 : (wv < 0 ? 16'd0 : (wv > 23'sd65535 ? 16'hffff : wv[15:0]));
        h_q <= !good ? 16'd0 : (hv < 0 ? 16'd0 : (hv > 23'sd65535 ? 16'hffff : hv[15:0]));
        den_q <= {in_q.tick, 1'b0};
        quo_q <= (good && in_q.tick != 0) ? in_q.tscale : 32'd0;
        rem_q <= '0;
      end
      R_DIV: begin
        if (!rsub[33]) begin
          rem_q <= rsub;
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rsh;
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/sps_picture_size_parser.sv
// ----------------------------------------------------------------------------
// SPS picture size parser
// Extracts cropped picture size, frame rate and status from an H.264 SPS.
// ----------------------------------------------------------------------------
// Bytes of one SPS NAL unit (start code removed, header byte first) enter on
// the slave side, one byte per transfer with tlast on the final byte. A front
// end flags emulation-prevention bytes and places bytes in a four-entry queue;
// the walker behind it consumes one bit per clock while a byte is queued and
// its last result has been taken, and skips a flagged byte whole. On the last
// byte the walker hands its summary to a result stage, which clamps the
// cropped sizes and divides the time scale by twice the tick with a
// bit-serial divider; no division is done when the tick is zero or the parse
// failed. One master-side transfer is produced per NAL unit; no other byte
// produces output.
`default_nettype none
module sps_picture_size_parser #(
  parameter int unsigned MAX_GOLOMB_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [7:0]   s_axis_tdata,   // [7:0] sps_byte
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata    // [15:0] pic_width, [31:16] pic_height,
                                      // [62:32] frame_rate, [65:63] parse_status
);
  logic q_valid, q_pop, res_valid, res_ready;
  sps_pkg::byte_entry_t q_entry;
  sps_pkg::walk_result_t res;
  logic [15:0] w, h;
  logic [30:0] rate;
  logic [2:0] stat;

  sps_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_last_i(s_axis_tlast),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_entry_o(q_entry)
  );

  sps_walker #(.MAX_GOLOMB_BITS(MAX_GOLOMB_BITS)) u_walker (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_entry_i(q_entry),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  sps_result u_result (
    .clk_i, .rst_ni,
    .res_valid_i(res_valid), .res_ready_o(res_ready), .res_i(res),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .width_o(w), .height_o(h), .rate_o(rate), .status_o(stat)
  );

  assign m_axis_tdata = {6'd0, stat, rate, h, w};
endmodule
`default_nettype wire

FILE: dv/sps_picture_size_parser_tb.sv
// ----------------------------------------------------------------------------
// SPS picture size parser testbench
// Streams SPS NAL units (directed, random, truncated and noise) into the parser
// and checks every result against a bit-serial predictor or a directed row's typed answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sps_picture_size_parser_tb;

  localparam int unsigned GolombLimit = 32;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandBytes   = 1950;

  // Syntax positions of the SPS walk, in bitstream order.
  typedef enum int {
    W_HDR, W_PROFILE, W_CONSTR, W_LEVEL, W_SPSID, W_CHROMA, W_RESID,
    W_DEPTHL, W_DEPTHC, W_BYPASS, W_SCALING, W_SCALFLAGS, W_LOG2FN,
    W_POCTYPE, W_POCLSB, W_DELTAZ, W_OFFNR, W_OFFTB, W_CYCLE, W_OFFREF,
    W_NUMREF, W_GAPS, W_WIDTH, W_HEIGHT, W_FRAMEONLY, W_MBAFF, W_DIRECT8,
    W_CROPFLAG, W_CROPL, W_CROPR, W_CROPT, W_CROPB, W_VUI, W_ARFLAG,
    W_ARIDC, W_SARW, W_SARH, W_OVERSCAN, W_OVERAPP, W_VSIG, W_VFMT,
    W_CDESC, W_COLOURS, W_CHROMALOC, W_LOCTOP, W_LOCBOT, W_TIMING,
    W_TICK, W_TSCALE, W_DONE, W_HALT
  } walk_step_e;

  typedef struct packed {
    logic [15:0]                 width;
    logic [15:0]                 height;
    logic [30:0]                 fps;
    logic [sps_pkg::StatusW-1:0] status;
  } pic_info_t;

  typedef struct {
    logic [7:0] data;
    bit         last;
    bit         typed;
    pic_info_t  info;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] sps_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // [15:0] width, [31:16] height, [62:32] fps,
                                    // [65:63] status

  sps_picture_size_parser uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: a copy of the parser's syntax walk.
  // --------------------------------------------------------------------------
  walk_step_e  step;
  int unsigned zeros_seen;     // consecutive zero bytes, capped at 2
  int unsigned lead_zeros;     // exp-Golomb prefix length
  logic [31:0] acc;
  int unsigned bits_left;
  bit          in_suffix;
  bit          high_prof;
  int unsigned cycle_left;
  logic [15:0] width_mbs, height_units;
  logic [1:0]  chroma;
  bit          frame_only;
  logic [15:0] crop [4];
  logic [31:0] tick, tscale;
  logic [2:0]  err_code;

  pic_info_t   info_q [$];     // results still awaited from the parser
  int unsigned fail_cnt, unit_cnt, result_cnt, ok_cnt;
  bit          idle_on = 1'b1;
  bit          drained = 1'b0;
  bit          drv_typed = 1'b0;
  pic_info_t   drv_info = '0;

  // Fixed field widths; zero means exp-Golomb.
  function automatic int unsigned fixed_len(walk_step_e s);
    case (s)
      W_HDR, W_PROFILE, W_CONSTR, W_LEVEL, W_SCALFLAGS, W_ARIDC: return 8;
      W_RESID, W_BYPASS, W_SCALING, W_DELTAZ, W_GAPS, W_FRAMEONLY, W_MBAFF,
      W_DIRECT8, W_CROPFLAG, W_VUI, W_ARFLAG, W_OVERSCAN, W_OVERAPP, W_VSIG,
      W_CDESC, W_CHROMALOC, W_TIMING: return 1;
      W_SARW, W_SARH: return 16;
      W_VFMT: return 4;
      W_COLOURS: return 24;
      W_TICK, W_TSCALE: return 32;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] sat16(longint unsigned v);
    return (v > 65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic void goto_step(walk_step_e s);
    step = s; acc = '0; lead_zeros = 0; in_suffix = 1'b0; bits_left = fixed_len(s);
  endfunction

  function automatic void stop_walk(logic [2:0] code);
    err_code = code; step = W_HALT;
  endfunction

  function automatic void clear_walk();
    zeros_seen = 0; width_mbs = '0; height_units = '0; chroma = 2'd1;
    frame_only = 1'b1; crop = '{default: '0}; tick = '0; tscale = '0;
    err_code = sps_pkg::ST_OK; high_prof = 1'b0; cycle_left = 0;
    goto_step(W_HDR);
  endfunction

  // A field has been read completely: store what matters and pick the next one.
  function automatic void field_done(logic [31:0] v);
    case (step)
      W_HDR: if (v[4:0] != 5'd7) stop_walk(sps_pkg::ST_NOT_SPS); else goto_step(W_PROFILE);
      W_PROFILE: begin
        high_prof = (v == 100 || v == 110 || v == 122 || v == 144);
        goto_step(W_CONSTR);
      end
      W_CONSTR: goto_step(W_LEVEL);
      W_LEVEL: goto_step(W_SPSID);
      W_SPSID: goto_step(high_prof ? W_CHROMA : W_LOG2FN);
      W_CHROMA: begin
        chroma = (v > 3) ? 2'd3 : v[1:0];
        goto_step(v == 3 ? W_RESID : W_DEPTHL);
      end
      W_RESID: goto_step(W_DEPTHL);
      W_DEPTHL: goto_step(W_DEPTHC);
      W_DEPTHC: goto_step(W_BYPASS);
      W_BYPASS: goto_step(W_SCALING);
      W_SCALING: begin
        // Scaling lists are not parsed; only the eight presence flags follow.
        if (v != 0) begin
          err_code = sps_pkg::ST_SCALING; goto_step(W_SCALFLAGS);
        end else begin
          goto_step(W_LOG2FN);
        end
      end
      W_SCALFLAGS: goto_step(W_LOG2FN);
      W_LOG2FN: goto_step(W_POCTYPE);
      W_POCTYPE: goto_step(v == 0 ? W_POCLSB : (v == 1 ? W_DELTAZ : W_NUMREF));
      W_POCLSB: goto_step(W_NUMREF);
      W_DELTAZ: goto_step(W_OFFNR);
      W_OFFNR: goto_step(W_OFFTB);
      W_OFFTB: goto_step(W_CYCLE);
      W_CYCLE: begin
        if (v > 255) begin
          stop_walk(sps_pkg::ST_OVERFLOW);
        end else begin
          cycle_left = v; goto_step(v != 0 ? W_OFFREF : W_NUMREF);
        end
      end
      W_OFFREF: begin
        cycle_left--; goto_step(cycle_left != 0 ? W_OFFREF : W_NUMREF);
      end
      W_NUMREF: goto_step(W_GAPS);
      W_GAPS: goto_step(W_WIDTH);
      W_WIDTH: begin
        width_mbs = sat16(longint'(v) + 1); goto_step(W_HEIGHT);
      end
      W_HEIGHT: begin
        height_units = sat16(longint'(v) + 1); goto_step(W_FRAMEONLY);
      end
      W_FRAMEONLY: begin
        frame_only = v[0]; goto_step(v[0] ? W_DIRECT8 : W_MBAFF);
      end
      W_MBAFF: goto_step(W_DIRECT8);
      W_DIRECT8: goto_step(W_CROPFLAG);
      W_CROPFLAG: goto_step(v != 0 ? W_CROPL : W_VUI);
      W_CROPL, W_CROPR, W_CROPT, W_CROPB: begin
        crop[int'(step) - int'(W_CROPL)] = sat16(v);
        goto_step(step == W_CROPB ? W_VUI : walk_step_e'(int'(step) + 1));
      end
      W_VUI: goto_step(v != 0 ? W_ARFLAG : W_DONE);
      W_ARFLAG: goto_step(v != 0 ? W_ARIDC : W_OVERSCAN);
      W_ARIDC: goto_step(v == 255 ? W_SARW : W_OVERSCAN);
      W_SARW: goto_step(W_SARH);
      W_SARH: goto_step(W_OVERSCAN);
      W_OVERSCAN: goto_step(v != 0 ? W_OVERAPP : W_VSIG);
      W_OVERAPP: goto_step(W_VSIG);
      W_VSIG: goto_step(v != 0 ? W_VFMT : W_CHROMALOC);
      W_VFMT: goto_step(W_CDESC);
      W_CDESC: goto_step(v != 0 ? W_COLOURS : W_CHROMALOC);
      W_COLOURS: goto_step(W_CHROMALOC);
      W_CHROMALOC: goto_step(v != 0 ? W_LOCTOP : W_TIMING);
      W_LOCTOP: goto_step(W_LOCBOT);
      W_LOCBOT: goto_step(W_TIMING);
      W_TIMING: goto_step(v != 0 ? W_TICK : W_DONE);
      W_TICK: begin
        tick = v; goto_step(W_TSCALE);
      end
      W_TSCALE: begin
        tscale = v; goto_step(W_DONE);
      end
      default: ;
    endcase
  endfunction

  function automatic void walk_bit(bit b);
    longint unsigned full;
    if (step >= W_DONE) return;
    if (fixed_len(step) == 0) begin
      if (!in_suffix) begin
        if (!b) begin
          lead_zeros++;
          if (lead_zeros >= GolombLimit) stop_walk(sps_pkg::ST_OVERFLOW);
        end else if (lead_zeros == 0) begin
          field_done('0);
        end else begin
          in_suffix = 1'b1; bits_left = lead_zeros; acc = '0;
        end
        return;
      end
      acc = {acc[30:0], b};
      bits_left--;
      if (bits_left == 0) begin
        full = ((64'd1 << lead_zeros) - 1) + acc;
        field_done(full[31:0]);
      end
      return;
    end
    acc = {acc[30:0], b};
    bits_left--;
    if (bits_left == 0) field_done(acc);
  endfunction

  // Consumes one accepted byte; returns 1 with the picture info on the last one.
  function automatic bit predict_byte(logic [7:0] b, bit last, output pic_info_t info);
    logic [2:0] st;
    longint     ux, uy, fm, w, h;
    info = '0;
    if (zeros_seen >= 2 && b == 8'h03) begin
      zeros_seen = 0;   // emulation-prevention byte carries no bits
    end else begin
      zeros_seen = (b == 0) ? ((zeros_seen >= 2) ? 2 : zeros_seen + 1) : 0;
      for (int i = 7; i >= 0; i--) walk_bit(b[i]);
    end
    if (!last) return 1'b0;
    if (err_code == sps_pkg::ST_NOT_SPS || err_code == sps_pkg::ST_OVERFLOW) st = err_code;
    else if (step != W_DONE) st = sps_pkg::ST_TRUNC;
    else st = err_code;
    if (st == sps_pkg::ST_OK || st == sps_pkg::ST_SCALING) begin
      fm = frame_only ? 1 : 2;
      case (chroma)
        2'd0: begin ux = 1; uy = fm; end
        2'd1: begin ux = 2; uy = 2 * fm; end
        2'd2: begin ux = 2; uy = fm; end
        default: begin ux = 1; uy = fm; end
      endcase
      w = longint'(width_mbs) * 16 - ux * (longint'(crop[0]) + crop[1]);
      h = fm * height_units * 16 - uy * (longint'(crop[2]) + crop[3]);
      info.width  = (w < 0) ? 16'd0 : sat16(w);
      info.height = (h < 0) ? 16'd0 : sat16(h);
      if (tick != 0) info.fps = 31'(longint'(tscale) / (2 * longint'(tick)));
    end
    info.status = st;
    clear_walk();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input side monitor: predict on every accepted byte.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pic_info_t info;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (predict_byte(s_axis_tdata, s_axis_tlast, info)) begin
        // Directed rows with a typed answer take precedence over the predictor.
        info_q.push_back(drv_typed ? drv_info : info);
        unit_cnt++;
      end
    end
  end

  // Output side: compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    pic_info_t got, exp_info;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.width  = m_axis_tdata[15:0];
      got.height = m_axis_tdata[31:16];
      got.fps    = m_axis_tdata[62:32];
      got.status = m_axis_tdata[65:63];
      result_cnt++;
      if (info_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_info = info_q.pop_front();
        if (exp_info.status == sps_pkg::ST_OK) ok_cnt++;
        if (got.width != exp_info.width) begin
          $display("%0t: width expected %0d actual %0d", $time, exp_info.width, got.width);
          fail_cnt++;
        end
        if (got.height != exp_info.height) begin
          $display("%0t: height expected %0d actual %0d", $time,
                   exp_info.height, got.height);
          fail_cnt++;
        end
        if (got.fps != exp_info.fps) begin
          $display("%0t: fps expected %0d actual %0d", $time, exp_info.fps, got.fps);
          fail_cnt++;
        end
        if (got.status != exp_info.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_info.status, got.status);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver back-pressure in random bursts.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
    end
  end

  // Watchdog: any run of cycles without a transfer on either side is bounded.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("FAIL sps_picture_size_parser");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  bit   rbsp [$];     // bits of the unit under construction
  int   sent_bytes = 0;

  // Drives one byte and holds it until the slave side takes the transfer.
  task automatic send_byte(logic [7:0] b, bit last, bit typed, pic_info_t info);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    drv_typed     <= typed;
    drv_info      <= info;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
  endtask

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) rbsp.push_back(v[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned code;
    int n;
    code = v + 1;
    n = 0;
    while ((code >> n) > 1) n++;
    repeat (n) rbsp.push_back(1'b0);
    for (int i = n; i >= 0; i--) rbsp.push_back(code[i]);
  endtask

  // Mostly small codes, some medium and huge ones, now and then a too-long prefix.
  task automatic put_rand_ue();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r < 28) put_ue($urandom_range(0, 5));
    else if (r < 36) put_ue($urandom_range(0, 300));
    else if (r < 39) put_ue($urandom);
    else begin
      put_bits(32'd0, 32);
      put_bits(32'd1, 1);
    end
  endtask

  task automatic build_sps();
    int unsigned profile, poc, cyc;
    bit flag;
    rbsp.delete();
    put_bits({$urandom_range(0, 7), 5'd7}, 8);
    case ($urandom_range(0, 6))
      0: profile = 66;  1: profile = 77;  2: profile = 100; 3: profile = 110;
      4: profile = 122; 5: profile = 144; default: profile = $urandom_range(0, 255);
    endcase
    put_bits(profile, 8);
    put_bits($urandom_range(0, 255), 8);
    put_bits($urandom_range(0, 255), 8);
    put_rand_ue();
    if (profile == 100 || profile == 110 || profile == 122 || profile == 144) begin
      put_ue($urandom_range(0, 5));
      if (rbsp.size() > 0 && $urandom_range(0, 2) == 0) begin
        put_ue(3); put_bits($urandom_range(0, 1), 1);
      end
      put_rand_ue(); put_rand_ue();
      put_bits($urandom_range(0, 1), 1);
      flag = ($urandom_range(0, 5) == 0);
      put_bits(flag, 1);
      if (flag) put_bits($urandom_range(0, 255), 8);
    end
    put_rand_ue();
    poc = $urandom_range(0, 3);
    put_ue(poc);
    if (poc == 0) begin
      put_rand_ue();
    end else if (poc == 1) begin
      put_bits($urandom_range(0, 1), 1);
      put_rand_ue(); put_rand_ue();
      cyc = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 4);
      put_ue(cyc);
      if (cyc <= 255) repeat (cyc) put_rand_ue();
    end
    put_rand_ue();
    put_bits($urandom_range(0, 1), 1);
    put_rand_ue(); put_rand_ue();
    flag = $urandom_range(0, 1);
    put_bits(flag, 1);
    if (!flag) put_bits($urandom_range(0, 1), 1);
    put_bits($urandom_range(0, 1), 1);
    flag = $urandom_range(0, 1);
    put_bits(flag, 1);
    if (flag) repeat (4) put_rand_ue();
    flag = ($urandom_range(0, 3) != 0);
    put_bits(flag, 1);
    if (flag) begin
      flag = $urandom_range(0, 1);
      put_bits(flag, 1);
      if (flag) begin
        flag = $urandom_range(0, 1);
        put_bits(flag ? 8'd255 : $urandom_range(0, 254), 8);
        if (flag) put_bits($urandom, 32);
      end
      flag = $urandom_range(0, 1);
      put_bits(flag, 1);
      if (flag) put_bits($urandom_range(0, 1), 1);
      flag = $urandom_range(0, 1);
      put_bits(flag, 1);
      if (flag) begin
        put_bits($urandom_range(0, 15), 4);
        flag = $urandom_range(0, 1);
        put_bits(flag, 1);
        if (flag) put_bits($urandom, 24);
      end
      flag = $urandom_range(0, 1);
      put_bits(flag, 1);
      if (flag) begin
        put_rand_ue(); put_rand_ue();
      end
      flag = ($urandom_range(0, 4) != 0);
      put_bits(flag, 1);
      if (flag) begin
        put_bits(($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 5000), 32);
        put_bits($urandom, 32);
      end
    end
    // Stop bit and a few random trailing bits.
    rbsp.push_back(1'b1);
    repeat ($urandom_range(0, 12)) rbsp.push_back($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) rbsp = rbsp[0:$urandom_range(0, rbsp.size() - 1)];
  endtask

  // Packs the bits into bytes, inserts emulation-prevention bytes and sends them.
  task automatic send_sps();
    logic [7:0] b, units [$];
    int zc;
    while (rbsp.size() % 8 != 0) rbsp.push_back(1'b0);
    zc = 0;
    for (int i = 0; i < rbsp.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7-k] = rbsp[i+k];
      if (zc >= 2 && b <= 8'h03) begin
        units.push_back(8'h03); zc = 0;
      end
      units.push_back(b);
      zc = (b == 0) ? zc + 1 : 0;
    end
    foreach (units[i]) send_byte(units[i], i == units.size() - 1, 1'b0, '0);
  endtask

  // Short runs of raw bytes, rich in zeros and 0x03, ending with tlast.
  task automatic send_noise();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = 8'h00;
        1: b = 8'h03;
        default: b = $urandom_range(0, 255);
      endcase
      send_byte(b, i == n - 1, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table: header checks, emulation prevention, a minimal baseline
  // unit and an over-long exp-Golomb prefix.
  // --------------------------------------------------------------------------
  stim_row_t rows [21];

  initial begin
    rows = '{
      '{8'h00, 1'b1, 1'b1, '{16'd0, 16'd0, 31'd0, sps_pkg::ST_NOT_SPS}},
      '{8'hff, 1'b1, 1'b1, '{16'd0, 16'd0, 31'd0, sps_pkg::ST_NOT_SPS}},
      '{8'h67, 1'b1, 1'b1, '{16'd0, 16'd0, 31'd0, sps_pkg::ST_TRUNC}},
      '{8'h03, 1'b1, 1'b1, '{16'd0, 16'd0, 31'd0, sps_pkg::ST_NOT_SPS}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h03, 1'b1, 1'b1, '{16'd0, 16'd0, 31'd0, sps_pkg::ST_NOT_SPS}},
      // Baseline, one macroblock each way, no cropping, no VUI.
      '{8'h67, 1'b0, 1'b0, '0},
      '{8'h42, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h1e, 1'b0, 1'b0, '0},
      '{8'hdd, 1'b0, 1'b0, '0},
      '{8'hc0, 1'b1, 1'b1, '{16'd16, 16'd16, 31'd0, sps_pkg::ST_OK}},
      // Thirty-two zero bits where the SPS id starts.
      '{8'h67, 1'b0, 1'b0, '0},
      '{8'h42, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{16'd0, 16'd0, 31'd0, sps_pkg::ST_OVERFLOW}}
    };
    clear_walk();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_byte(rows[i].data, rows[i].last, rows[i].typed, rows[i].info);

    sent_bytes = 0;
    while (sent_bytes < RandBytes) begin
      // The last stretch runs with neither side idling.
      if (sent_bytes > RandBytes - 250) idle_on = 1'b0;
      if ($urandom_range(0, 5) == 0) begin
        send_noise();
      end else begin
        build_sps();
        send_sps();
      end
      // Once along the way, let the parser drain completely before going on.
      if (!drained && unit_cnt >= 40) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (info_q.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (info_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d units in %0d random bytes plus the directed table.",
             unit_cnt, sent_bytes);
    $display("Checked %0d results, %0d of them with a clean parse.", result_cnt, ok_cnt);
    if (fail_cnt == 0) begin
      $display("PASS sps_picture_size_parser");
    end else begin
      $display("FAIL sps_picture_size_parser");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_walker.sv
rtl/sps_result.sv
rtl/sps_picture_size_parser.sv
dv/sps_picture_size_parser_tb.sv
